### rtl/core/sscst_pkg.sv
`timescale 1ns / 1ps
package sscst_pkg;
	localparam int COORD_W = 32;
	localparam int RAD_W = 31;
	localparam int D_W = 33;
	localparam int RSUM_W = 32;
	localparam int P_W = 66;
	localparam int Q_W = 66;
	localparam int R_W = 64;
	localparam int RM_W = 66;
	localparam int HALF_W = 33;
	localparam int K_W = 132;
	localparam int S_W = K_W / 2;
	localparam int N_W = 68;
	localparam int IN_TDATA_W = 256;
	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
		logic signed [D_W-1:0] dz;
		logic [RSUM_W-1:0] rsum;
	} front_item_t;
endpackage

### rtl/core/swept_sphere_collision_time_core.sv
`timescale 1ns / 1ps
// Swept sphere-sphere contact time. Takes one sphere pair per cycle while the queue
// is not full and returns one beat per pair, in order: hit and the earlier contact root
// in [0,1] as unsigned Q1.TIME_FRAC_BITS (0 when no hit). Pairs with no relative motion
// never hit. The result passes through one input stage, the queue, six product and
// discriminant stages, the 66-stage square root pipeline, two root select stages, the
// TIME_FRAC_BITS + 1 stage one-bit-per-stage divider and the output register.
// A QUEUE_DEPTH-entry queue (4 by default) sits between the input stage and the
// arithmetic pipeline, and that pipeline holds while the output beat is not taken.
module swept_sphere_collision_time_core #(
	parameter int TIME_FRAC_BITS = sscst_pkg::TIME_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = sscst_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_offset_x, _y, _z, end_offset_x, _y, _z, radius_a, radius_b
	input  logic [sscst_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit, impact_time
	output logic [((TIME_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
	localparam int OW = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8;
	localparam int FW = $bits(sscst_pkg::front_item_t);

	logic push, full, pop, q_valid, hit;
	sscst_pkg::front_item_t f_item, b_item;
	logic [FW-1:0] q_rdata;
	logic [TIME_FRAC_BITS:0] t;

	sscst_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.push(push), .full(full), .item(f_item)
	);

	sscst_fifo #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(f_item), .full(full),
		.pop(pop), .not_empty(q_valid), .rdata(q_rdata)
	);

	assign b_item = q_rdata;

	sscst_back #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(q_valid), .pop(pop), .item(b_item),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_hit(hit), .res_time(t)
	);

	assign m_axis_tdata = {(OW - TIME_FRAC_BITS - 2)'(0), t, hit};
endmodule

### rtl/core/sscst_front.sv
`timescale 1ns / 1ps
module sscst_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sscst_pkg::IN_TDATA_W-1:0] in_data,
	output logic push,
	input  logic full,
	output sscst_pkg::front_item_t item
);
	logic valid_q;
	sscst_pkg::front_item_t item_q;
	logic signed [31:0] sx, sy, sz, ex, ey, ez;
	logic [30:0] ra, rb;

	assign sx = in_data[31:0];
	assign sy = in_data[63:32];
	assign sz = in_data[95:64];
	assign ex = in_data[127:96];
	assign ey = in_data[159:128];
	assign ez = in_data[191:160];
	assign ra = in_data[222:192];
	assign rb = in_data[253:223];

	assign push = valid_q && !full;
	assign in_ready = !valid_q || push;
	assign item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// relative motion over the frame and combined radius
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.cx <= sx;
			item_q.cy <= sy;
			item_q.cz <= sz;
			item_q.dx <= 33'(ex) - 33'(sx);
			item_q.dy <= 33'(ey) - 33'(sy);
			item_q.dz <= 33'(ez) - 33'(sz);
			item_q.rsum <= {1'b0, ra} + {1'b0, rb};
		end
	end
endmodule

### rtl/core/sscst_fifo.sv
`timescale 1ns / 1ps
module sscst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_pop;

	assign full = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign rdata = mem_q[rd_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(do_pop);
		end
	end
endmodule

### rtl/core/sscst_sqrt.sv
`timescale 1ns / 1ps
module sscst_sqrt #(
	parameter int KW = 132,
	parameter int SB = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ce,
	input  logic in_valid,
	input  logic [KW-1:0] k,
	input  logic [SB-1:0] sb_in,
	output logic out_valid,
	output logic [KW/2-1:0] root,
	output logic [SB-1:0] sb_out
);
	localparam int SW = KW / 2;
	localparam int RW = SW + 3;
	logic [KW-1:0] k_s [SW+1];
	logic [RW-1:0] rem_s [SW+1];
	logic [SW-1:0] root_s [SW+1];
	logic [SB-1:0] sb_s [SW+1];
	logic v_s [SW+1];

	assign k_s[0] = k;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign sb_s[0] = sb_in;
	assign v_s[0] = in_valid;

	// one result bit per stage, restoring digit recurrence
	for (genvar i = 0; i < SW; i++) begin : g_st
		logic [RW-1:0] rem_sh, trial;
		logic ge;
		assign rem_sh = {rem_s[i][RW-3:0], k_s[i][KW-1:KW-2]};
		assign trial = {1'b0, root_s[i], 2'b01};
		assign ge = rem_sh >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ce) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				k_s[i+1] <= {k_s[i][KW-3:0], 2'b00};
				rem_s[i+1] <= ge ? rem_sh - trial : rem_sh;
				root_s[i+1] <= {root_s[i][SW-2:0], ge};
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[SW];
	assign root = root_s[SW];
	assign sb_out = sb_s[SW];
endmodule

### rtl/core/sscst_div.sv
`timescale 1ns / 1ps
module sscst_div #(
	parameter int NW = 66,
	parameter int FB = 16,
	parameter int SB = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ce,
	input  logic in_valid,
	input  logic [NW-1:0] n,
	input  logic [NW-1:0] p,
	input  logic [SB-1:0] sb_in,
	output logic out_valid,
	output logic [FB:0] quo,
	output logic [SB-1:0] sb_out
);
	localparam int ST = FB + 1;
	logic [NW:0] rem_s [ST+1];
	logic [NW-1:0] p_s [ST+1];
	logic [FB:0] q_s [ST+1];
	logic [SB-1:0] sb_s [ST+1];
	logic v_s [ST+1];

	assign rem_s[0] = {1'b0, n};
	assign p_s[0] = p;
	assign q_s[0] = '0;
	assign sb_s[0] = sb_in;
	assign v_s[0] = in_valid;

	// first stage settles the integer bit, the rest one fraction bit each
	for (genvar j = 0; j < ST; j++) begin : g_st
		logic [NW:0] t;
		logic ge;
		assign t = (j == 0) ? rem_s[j] : {rem_s[j][NW-1:0], 1'b0};
		assign ge = t >= {1'b0, p_s[j]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (ce) begin
				v_s[j+1] <= v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[j+1] <= ge ? t - {1'b0, p_s[j]} : t;
				p_s[j+1] <= p_s[j];
				q_s[j+1] <= {q_s[j][FB-1:0], ge};
				sb_s[j+1] <= sb_s[j];
			end
		end
	end

	assign out_valid = v_s[ST];
	assign quo = q_s[ST];
	assign sb_out = sb_s[ST];
endmodule

### rtl/core/sscst_back.sv
`timescale 1ns / 1ps
module sscst_back #(
	parameter int TIME_FRAC_BITS = sscst_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic pop,
	input  sscst_pkg::front_item_t item,
	output logic res_valid,
	input  logic res_ready,
	output logic res_hit,
	output logic [TIME_FRAC_BITS:0] res_time
);
	localparam int PW = sscst_pkg::P_W;
	localparam int HW = sscst_pkg::HALF_W;
	localparam int KW = sscst_pkg::K_W;
	localparam int SW = sscst_pkg::S_W;
	localparam int NW = sscst_pkg::N_W;
	localparam int SBW = 1 + sscst_pkg::Q_W + PW;

	logic ce;
	assign ce = !res_valid || res_ready;
	assign pop = ce && item_valid;

	// s1: products
	logic v_s1;
	logic signed [65:0] dxx_s1, dyy_s1, dzz_s1;
	logic signed [64:0] cdx_s1, cdy_s1, cdz_s1;
	logic signed [63:0] ccx_s1, ccy_s1, ccz_s1;
	logic [63:0] rs_s1;
	// s2: dot products
	logic v_s2;
	logic [PW-1:0] p_s2;
	logic signed [65:0] q_s2, rm_s2;
	// s3: magnitudes
	logic v_s3, rneg_s3;
	logic [PW-1:0] p_s3, qa_s3, ra_s3;
	logic signed [65:0] q_s3;
	// s4: partial products
	logic v_s4, rneg_s4;
	logic [2*HW-1:0] qhh_s4, qhl_s4, qll_s4, phh_s4, phl_s4, plh_s4, pll_s4;
	logic [PW-1:0] p_s4;
	logic signed [65:0] q_s4;
	// s5: full q^2 and p*r
	logic v_s5, rneg_s5;
	logic [KW-1:0] q2_s5, pr_s5;
	logic [PW-1:0] p_s5;
	logic signed [65:0] q_s5;
	// s6: discriminant
	logic v_s6, ok_s6;
	logic [KW-1:0] k_s6;
	logic [PW-1:0] p_s6;
	logic signed [65:0] q_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (ce) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic [KW:0] k_full;
	assign k_full = rneg_s5 ? {1'b0, q2_s5} + {1'b0, pr_s5} : {1'b0, q2_s5} - {1'b0, pr_s5};

	always_ff @(posedge clk) begin
		if (ce) begin
			dxx_s1 <= item.dx * item.dx;
			dyy_s1 <= item.dy * item.dy;
			dzz_s1 <= item.dz * item.dz;
			cdx_s1 <= 65'(item.cx) * 65'(item.dx);
			cdy_s1 <= 65'(item.cy) * 65'(item.dy);
			cdz_s1 <= 65'(item.cz) * 65'(item.dz);
			ccx_s1 <= 64'(item.cx) * 64'(item.cx);
			ccy_s1 <= 64'(item.cy) * 64'(item.cy);
			ccz_s1 <= 64'(item.cz) * 64'(item.cz);
			rs_s1 <= 64'(item.rsum) * 64'(item.rsum);

			p_s2 <= PW'(dxx_s1) + PW'(dyy_s1) + PW'(dzz_s1);
			q_s2 <= 66'(cdx_s1) + 66'(cdy_s1) + 66'(cdz_s1);
			rm_s2 <= 66'($unsigned(ccx_s1)) + 66'($unsigned(ccy_s1))
				+ 66'($unsigned(ccz_s1)) - 66'(rs_s1);

			p_s3 <= p_s2;
			q_s3 <= q_s2;
			qa_s3 <= q_s2[65] ? PW'(-q_s2) : PW'(q_s2);
			ra_s3 <= rm_s2[65] ? PW'(-rm_s2) : PW'(rm_s2);
			rneg_s3 <= rm_s2[65];

			qhh_s4 <= qa_s3[2*HW-1:HW] * qa_s3[2*HW-1:HW];
			qhl_s4 <= qa_s3[2*HW-1:HW] * qa_s3[HW-1:0];
			qll_s4 <= qa_s3[HW-1:0] * qa_s3[HW-1:0];
			phh_s4 <= p_s3[2*HW-1:HW] * ra_s3[2*HW-1:HW];
			phl_s4 <= p_s3[2*HW-1:HW] * ra_s3[HW-1:0];
			plh_s4 <= p_s3[HW-1:0] * ra_s3[2*HW-1:HW];
			pll_s4 <= p_s3[HW-1:0] * ra_s3[HW-1:0];
			p_s4 <= p_s3;
			q_s4 <= q_s3;
			rneg_s4 <= rneg_s3;

			q2_s5 <= (KW'(qhh_s4) << (2*HW)) + (KW'(qhl_s4) << (HW+1)) + KW'(qll_s4);
			pr_s5 <= (KW'(phh_s4) << (2*HW)) + ((KW'(phl_s4) + KW'(plh_s4)) << HW)
				+ KW'(pll_s4);
			p_s5 <= p_s4;
			q_s5 <= q_s4;
			rneg_s5 <= rneg_s4;

			ok_s6 <= !k_full[KW] && (p_s5 != '0);
			k_s6 <= k_full[KW] ? '0 : k_full[KW-1:0];
			p_s6 <= p_s5;
			q_s6 <= q_s5;
		end
	end

	logic sq_v;
	logic [SW-1:0] sq_root;
	logic [SBW-1:0] sq_sb;

	sscst_sqrt #(.KW(KW), .SB(SBW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s6), .k(k_s6), .sb_in({ok_s6, q_s6, p_s6}),
		.out_valid(sq_v), .root(sq_root), .sb_out(sq_sb)
	);

	// s7: root numerators, s8: pick the earlier root in the frame
	logic v_s7, ok_s7, v_s8, hit_s8;
	logic signed [NW-1:0] n1_s7, n2_s7;
	logic [PW-1:0] p_s7, p_s8, n_s8;
	logic signed [65:0] sq_q;
	logic in1, in2;

	assign sq_q = sq_sb[PW +: 66];
	assign in1 = !n1_s7[NW-1] && (n1_s7[NW-2:0] <= (NW-1)'(p_s7));
	assign in2 = !n2_s7[NW-1] && (n2_s7[NW-2:0] <= (NW-1)'(p_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (ce) begin
			v_s7 <= sq_v;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			n1_s7 <= -NW'(sq_q) - NW'(sq_root);
			n2_s7 <= -NW'(sq_q) + NW'(sq_root);
			p_s7 <= sq_sb[PW-1:0];
			ok_s7 <= sq_sb[SBW-1];
			hit_s8 <= ok_s7 && (in1 || in2);
			n_s8 <= in1 ? PW'(n1_s7) : (in2 ? PW'(n2_s7) : '0);
			p_s8 <= p_s7;
		end
	end

	logic dv_v, dv_hit;
	logic [TIME_FRAC_BITS:0] dv_q;

	sscst_div #(.NW(PW), .FB(TIME_FRAC_BITS), .SB(1)) u_div (
		.clk(clk), .arst_n(arst_n), .ce(ce),
		.in_valid(v_s8), .n(n_s8), .p(p_s8), .sb_in(hit_s8),
		.out_valid(dv_v), .quo(dv_q), .sb_out(dv_hit)
	);

	// output register
	logic valid_q, hit_q;
	logic [TIME_FRAC_BITS:0] time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ce) begin
			valid_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hit_q <= dv_hit;
			time_q <= dv_hit ? dv_q : '0;
		end
	end

	assign res_valid = valid_q;
	assign res_hit = hit_q;
	assign res_time = time_q;
endmodule
